### rtl/core/npdf_pkg.sv
// ----------------------------------------------------------------------------
// npdf_pkg
// Shared types, constants and address helper for the nearest paint distance
// fill block.
// ----------------------------------------------------------------------------
package npdf_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int PIX_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int PIX_AW     = $clog2(PIX_DEPTH);
  localparam int LINE_DEPTH = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int DIM_W      = 9;
  localparam int CNT_W      = 17;
  localparam int DIST_W     = 32;
  localparam int PAINT_W    = 12;

  localparam logic [DIST_W-1:0] NO_SEED = 32'hFFFF_FFFD;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam logic [1:0] PASS_ROW_FWD = 2'd0;
  localparam logic [1:0] PASS_ROW_BWD = 2'd1;
  localparam logic [1:0] PASS_COL_DN  = 2'd2;
  localparam logic [1:0] PASS_COL_UP  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_LINE,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_REF_RD,
    ST_REF_WAIT,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_DIV,
    ST_TAKE,
    ST_UPDATE,
    ST_END,
    ST_FILL,
    ST_NEXT
  } state_t;

  function automatic logic [PIX_AW-1:0] pix_index(
    input logic [1:0]       pass,
    input logic [DIM_W-1:0] l,
    input logic [DIM_W-1:0] i,
    input logic [DIM_W-1:0] w,
    input logic [DIM_W-1:0] h
  );
    logic [2*DIM_W-1:0] row;
    logic [2*DIM_W-1:0] col;
    logic [2*DIM_W-1:0] sum;
    begin
      case (pass)
        PASS_ROW_FWD: begin
          row = {{DIM_W{1'b0}}, l};
          col = {{DIM_W{1'b0}}, i};
        end
        PASS_ROW_BWD: begin
          row = {{DIM_W{1'b0}}, l};
          col = {{DIM_W{1'b0}}, w - 9'd1 - i};
        end
        PASS_COL_DN: begin
          row = {{DIM_W{1'b0}}, i};
          col = {{DIM_W{1'b0}}, l};
        end
        default: begin
          row = {{DIM_W{1'b0}}, h - 9'd1 - i};
          col = {{DIM_W{1'b0}}, l};
        end
      endcase
      sum = row[DIM_W-1:0] * w + col;
      return sum[PIX_AW-1:0];
    end
  endfunction

endpackage

### rtl/core/npdf_ram.sv
// ----------------------------------------------------------------------------
// npdf_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module npdf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/nearest_paint_distance_fill.sv
// ----------------------------------------------------------------------------
// nearest_paint_distance_fill
// Loads a raster, runs a four pass squared distance transform that carries
// the nearest seed's paint, and streams the result back in row order.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       sink       in_valid / in_stall  func, tone, paint
//  out      source     out_valid/out_stall  out_paint, sq_distance, last
//  cfg      sink       cfg_write            cfg_index, cfg_data
//
//  A load writes the stores; a read registers its word at the output once
//  that is free, so an output stall holds it. The last load of a raster
//  starts the transform: per line a copy and bookkeeping, per range a scan
//  of candidates, some of them through the 32 bit restoring divider, then
//  a write per pixel. Reset is synchronous; the stores hold no reset value.
//  in_stall is high whenever the sequencer is not idle.
// ----------------------------------------------------------------------------
module nearest_paint_distance_fill
  import npdf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic [7:0]         tone,
  input  logic [PAINT_W-1:0] paint,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [PAINT_W-1:0] out_paint,
  output logic [DIST_W-1:0]  sq_distance,
  output logic               last,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [DIM_W-1:0]   cfg_data
);

  state_t state, state_next;

  logic [DIM_W-1:0]  cfg_width, cfg_height;
  logic [CNT_W-1:0]  load_count, read_count;
  logic              rd_last;
  logic [1:0]        pass;
  logic [DIM_W-1:0]  line, cidx, pos, ref_i, d, dnew;
  logic [DIM_W:0]    fill_end;
  logic [DIST_W-1:0] a_val, dmax, nd, div_quo;
  logic [PAINT_W-1:0] ref_paint;
  logic [DIM_W-1:0]  div_rem;
  logic [4:0]        div_cnt;

  logic [DIM_W-1:0]  w_eff, h_eff, len, lines, idx_sel;
  logic [CNT_W-1:0]  total, lc_eff, rc_eff;
  logic [PIX_AW-1:0] pix_addr;
  logic              in_acc, out_free, scan_go, out_pop;
  logic [DIM_W:0]    j_idx, end_raw, end_cl;
  logic [DIM_W-1:0]  m_len, off;
  logic [2*DIM_W-1:0] off_sq;
  logic [DIM_W:0]    div_sh;
  logic [DIST_W-1:0] d_ext, take_sum, take_x;

  logic               dm_we, dm_re, pm_we, pm_re, lm_we, lm_re;
  logic [PIX_AW-1:0]  dm_wa, dm_ra, pm_wa, pm_ra;
  logic [LINE_AW-1:0] lm_wa, lm_ra;
  logic [DIST_W-1:0]  dm_wd, dm_q, lm_wd, lm_q;
  logic [PAINT_W-1:0] pm_wd, pm_q;

  assign w_eff  = (cfg_width == '0) ? 9'd1 :
                  (cfg_width > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : cfg_width;
  assign h_eff  = (cfg_height == '0) ? 9'd1 :
                  (cfg_height > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : cfg_height;
  assign total  = {8'b0, w_eff} * {8'b0, h_eff};
  assign lc_eff = (load_count >= total) ? '0 : load_count;
  assign rc_eff = (read_count >= total) ? '0 : read_count;
  assign len    = (pass < PASS_COL_DN) ? w_eff : h_eff;
  assign lines  = (pass < PASS_COL_DN) ? h_eff : w_eff;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_pop  = out_valid && !out_stall;
  assign out_free = !out_valid || !out_stall;

  assign j_idx   = {1'b0, ref_i} + {1'b0, d};
  assign scan_go = ({23'b0, d} <= dmax) && (j_idx < {1'b0, len});

  assign m_len   = ({23'b0, d} < dmax) ? d : dmax[DIM_W-1:0];
  assign end_raw = {1'b0, ref_i} + {1'b0, m_len};
  assign end_cl  = (end_raw > {1'b0, len}) ? {1'b0, len} :
                   (end_raw <= {1'b0, pos}) ? ({1'b0, pos} + 10'd1) : end_raw;

  assign off    = pos - ref_i;
  assign off_sq = off * off;

  assign div_sh   = {div_rem, div_quo[DIST_W-1]};
  assign d_ext    = {23'b0, d};
  assign take_sum = d_ext + div_quo + 32'd1;
  assign take_x   = {1'b0, take_sum[DIST_W-1:1]};

  always_comb begin
    case (state)
      ST_COPY_RD, ST_COPY_WR: idx_sel = cidx;
      ST_REF_RD:              idx_sel = ref_i;
      default:                idx_sel = pos;
    endcase
  end

  assign pix_addr = pix_index(pass, line, idx_sel, w_eff, h_eff);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (func == FUNC_READ) begin
            state_next = ST_READ;
          end else if (lc_eff + 17'd1 == total) begin
            state_next = ST_LINE;
          end
        end
      end
      ST_READ:      if (out_free) state_next = ST_IDLE;
      ST_LINE:      state_next = ST_COPY_RD;
      ST_COPY_RD:   state_next = ST_COPY_WR;
      ST_COPY_WR:   state_next = (cidx == len - 9'd1) ? ST_REF_RD : ST_COPY_RD;
      ST_REF_RD:    state_next = ST_REF_WAIT;
      ST_REF_WAIT:  state_next = ST_SCAN;
      ST_SCAN:      state_next = scan_go ? ST_SCAN_WAIT : ST_END;
      ST_SCAN_WAIT: state_next = (lm_q < a_val) ? ST_UPDATE : ST_DIV;
      ST_DIV:       if (div_cnt == 5'd31) state_next = ST_TAKE;
      ST_TAKE:      state_next = ST_UPDATE;
      ST_UPDATE:    state_next = ST_SCAN;
      ST_END:       state_next = ST_FILL;
      ST_FILL: begin
        if ({1'b0, pos} + 10'd1 == fill_end) begin
          state_next = ({1'b0, pos} + 10'd1 < {1'b0, len}) ? ST_REF_RD : ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (line + 9'd1 == lines && pass == PASS_COL_UP) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_LINE;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    dm_we = 1'b0; dm_wa = pix_addr; dm_wd = a_val + {14'b0, off_sq};
    dm_re = 1'b0; dm_ra = pix_addr;
    pm_we = 1'b0; pm_wa = pix_addr; pm_wd = ref_paint;
    pm_re = 1'b0; pm_ra = pix_addr;
    lm_we = 1'b0; lm_wa = cidx[LINE_AW-1:0]; lm_wd = dm_q;
    lm_re = 1'b0; lm_ra = ref_i[LINE_AW-1:0];
    case (state)
      ST_IDLE: begin
        if (in_acc && func == FUNC_LOAD) begin
          dm_we = 1'b1;
          pm_we = 1'b1;
          dm_wa = lc_eff[PIX_AW-1:0];
          pm_wa = lc_eff[PIX_AW-1:0];
          dm_wd = (tone != '0 || paint != '0) ? '0 : NO_SEED;
          pm_wd = paint;
        end else if (in_acc) begin
          dm_re = 1'b1;
          pm_re = 1'b1;
          dm_ra = rc_eff[PIX_AW-1:0];
          pm_ra = rc_eff[PIX_AW-1:0];
        end
      end
      ST_COPY_RD: dm_re = 1'b1;
      ST_COPY_WR: lm_we = 1'b1;
      ST_REF_RD: begin
        lm_re = 1'b1;
        pm_re = 1'b1;
      end
      ST_SCAN: begin
        lm_re = scan_go;
        lm_ra = j_idx[LINE_AW-1:0];
      end
      ST_FILL: begin
        dm_we = 1'b1;
        pm_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cfg_width  <= 9'd256;
      cfg_height <= 9'd256;
      load_count <= '0;
      read_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        if (cfg_index == REG_WIDTH) cfg_width <= cfg_data;
        else cfg_height <= cfg_data;
      end
      if (state == ST_READ && out_free) begin
        out_valid <= 1'b1;
      end else if (out_pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc && func == FUNC_LOAD) begin
            load_count <= lc_eff + 17'd1;
            pass       <= PASS_ROW_FWD;
            line       <= '0;
          end else if (in_acc) begin
            read_count <= rc_eff + 17'd1;
            rd_last    <= (rc_eff == total - 17'd1);
          end
        end
        ST_READ: begin
          if (out_free) begin
            out_paint   <= pm_q;
            sq_distance <= dm_q;
            last        <= rd_last;
          end
        end
        ST_LINE: begin
          pos   <= '0;
          ref_i <= '0;
          cidx  <= '0;
        end
        ST_COPY_WR: cidx <= cidx + 9'd1;
        ST_REF_WAIT: begin
          a_val     <= lm_q;
          ref_paint <= pm_q;
          d         <= 9'd1;
          dnew      <= '0;
          dmax      <= 32'hFFFF_FFFF;
        end
        ST_SCAN_WAIT: begin
          nd      <= d_ext;
          div_rem <= '0;
          div_quo <= lm_q - a_val;
          div_cnt <= '0;
        end
        ST_DIV: begin
          div_cnt <= div_cnt + 5'd1;
          if (div_sh >= {1'b0, d}) begin
            div_rem <= 9'(div_sh - {1'b0, d});
            div_quo <= {div_quo[DIST_W-2:0], 1'b1};
          end else begin
            div_rem <= div_sh[DIM_W-1:0];
            div_quo <= {div_quo[DIST_W-2:0], 1'b0};
          end
        end
        ST_TAKE: nd <= (take_x > d_ext) ? take_x : d_ext;
        ST_UPDATE: begin
          if (nd <= dmax) begin
            dnew <= d;
            dmax <= nd;
          end
          d <= d + 9'd1;
        end
        ST_END: fill_end <= end_cl;
        ST_FILL: begin
          pos <= pos + 9'd1;
          if ({1'b0, pos} + 10'd1 == fill_end) ref_i <= ref_i + dnew;
        end
        ST_NEXT: begin
          if (line + 9'd1 == lines) begin
            line <= '0;
            pass <= pass + 2'd1;
            if (pass == PASS_COL_UP) read_count <= '0;
          end else begin
            line <= line + 9'd1;
          end
        end
        default: ;
      endcase
    end
  end

  npdf_ram #(.WIDTH(DIST_W), .DEPTH(PIX_DEPTH)) u_dist (
    .clk(clk), .we(dm_we), .waddr(dm_wa), .wdata(dm_wd),
    .re(dm_re), .raddr(dm_ra), .rdata(dm_q)
  );

  npdf_ram #(.WIDTH(PAINT_W), .DEPTH(PIX_DEPTH)) u_paint (
    .clk(clk), .we(pm_we), .waddr(pm_wa), .wdata(pm_wd),
    .re(pm_re), .raddr(pm_ra), .rdata(pm_q)
  );

  npdf_ram #(.WIDTH(DIST_W), .DEPTH(LINE_DEPTH)) u_line (
    .clk(clk), .we(lm_we), .waddr(lm_wa), .wdata(lm_wd),
    .re(lm_re), .raddr(lm_ra), .rdata(lm_q)
  );

  a_fill_in_line: assert property (@(posedge clk) disable iff (rst)
    state == ST_FILL |-> pos < len)
    else $error("fill cursor beyond line");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> d != '0)
    else $error("divide by zero offset");

  a_take_floor: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPDATE |-> nd >= d_ext)
    else $error("takeover below offset");

  a_scan_ref: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> ref_i < len)
    else $error("reference beyond line");

endmodule

### verif/nearest_paint_distance_fill_tb.sv
// ----------------------------------------------------------------------------
// nearest_paint_distance_fill_tb
// Self-checking bench: loads rasters of varied size and seed density, reads
// the fill back and compares every result word with a local model of the
// four pass distance transform. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module nearest_paint_distance_fill_tb;
  import npdf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic               func;
    logic [7:0]         tone;
    logic [PAINT_W-1:0] paint;
    bit                 typed;
    logic [PAINT_W-1:0] e_paint;
    logic [DIST_W-1:0]  e_dist;
    logic               e_last;
  } stim_row_t;

  typedef struct {
    logic [PAINT_W-1:0] paint;
    logic [DIST_W-1:0]  sq_dist;
    logic               last;
  } fill_word_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               func = FUNC_LOAD;
  logic [7:0]         tone = '0;
  logic [PAINT_W-1:0] paint = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [PAINT_W-1:0] out_paint;
  logic [DIST_W-1:0]  sq_distance;
  logic               last;
  logic               cfg_write = 1'b0;
  logic               cfg_index = REG_WIDTH;
  logic [DIM_W-1:0]   cfg_data = '0;

  nearest_paint_distance_fill dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // model state
  logic [DIST_W-1:0]  dist_mem [PIX_DEPTH];
  logic [PAINT_W-1:0] paint_mem[PIX_DEPTH];
  logic [DIST_W-1:0]  line_buf [LINE_DEPTH];
  int unsigned        load_cnt = 0;
  int unsigned        read_cnt = 0;
  logic [DIM_W-1:0]   width_reg = 9'd256;
  logic [DIM_W-1:0]   height_reg = 9'd256;

  fill_word_t fill_q[$];
  int         errors = 0;
  int         items = 0;
  bit         calm = 0;
  bit         hold_req = 0;

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  function automatic longint unsigned takeover(longint unsigned a, longint unsigned b,
                                               longint unsigned d);
    longint unsigned x;
    if (b < a) return d;
    x = ((d + (b - a) / d + 1) & 64'hFFFF_FFFF) / 2;
    return (x > d) ? x : d;
  endfunction

  function automatic int unsigned px(int p, int unsigned l, int unsigned i,
                                     int unsigned w, int unsigned h);
    case (p)
      0: return l * w + i;
      1: return l * w + (w - 1 - i);
      2: return i * w + l;
      default: return (h - 1 - i) * w + l;
    endcase
  endfunction

  task automatic relax_pass(int p, int unsigned w, int unsigned h);
    int unsigned len, lines, l, i, pos, anchor, j, rp, q;
    longint unsigned d, dnew, dmax, stop, off, nd;
    len = (p < 2) ? w : h;
    lines = (p < 2) ? h : w;
    for (l = 0; l < lines; l++) begin
      pos = 0;
      anchor = 0;
      for (i = 0; i < len; i++) line_buf[i] = dist_mem[px(p, l, i, w, h)];
      while (pos < len) begin
        d = 1;
        dnew = 0;
        dmax = 64'hFFFF_FFFF;
        j = anchor + 1;
        rp = px(p, l, anchor, w, h);
        while (d <= dmax && j < len) begin
          nd = takeover(line_buf[anchor], line_buf[j], d);
          if (nd <= dmax) begin
            dnew = d;
            dmax = nd;
          end
          d++;
          j++;
        end
        stop = anchor + ((d < dmax) ? d : dmax);
        if (stop > len) stop = len;
        if (stop <= pos) stop = pos + 1;
        off = 64'(32'(pos - anchor));
        for (; pos < stop; pos++, off++) begin
          q = px(p, l, pos, w, h);
          dist_mem[q] = 32'(longint'(line_buf[anchor]) + off * off);
          paint_mem[q] = paint_mem[rp];
        end
        anchor = anchor + 32'(dnew);
      end
    end
  endtask

  task automatic predict_word(logic f, logic [7:0] t, logic [PAINT_W-1:0] pt);
    int unsigned w, h, total;
    fill_word_t r;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    total = w * h;
    if (f == FUNC_LOAD) begin
      if (load_cnt >= total) load_cnt = 0;
      dist_mem[load_cnt] = (t != 0 || pt != 0) ? 32'd0 : NO_SEED;
      paint_mem[load_cnt] = pt;
      load_cnt++;
      if (load_cnt == total) begin
        for (int p = 0; p < 4; p++) relax_pass(p, w, h);
        read_cnt = 0;
      end
    end else begin
      if (read_cnt >= total) read_cnt = 0;
      r.paint = paint_mem[read_cnt];
      r.sq_dist = dist_mem[read_cnt];
      r.last = (read_cnt == total - 1);
      read_cnt++;
      fill_q.push_back(r);
    end
  endtask

  // offer one word, hold until accepted
  task automatic offer(logic f, logic [7:0] t, logic [PAINT_W-1:0] pt);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    tone <= t;
    paint <= pt;
    do @(posedge clk); while (in_stall);
    predict_word(f, t, pt);
    items++;
  endtask

  task automatic write_reg(logic idx, logic [DIM_W-1:0] v);
    in_valid <= 1'b0;
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_WIDTH) width_reg = v;
    else height_reg = v;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (fill_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // receiver
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_req = 0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (fill_q.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        fill_word_t e;
        e = fill_q.pop_front();
        if (out_paint !== e.paint) begin
          $error("out_paint expected %0d actual %0d", e.paint, out_paint);
          errors++;
        end
        if (sq_distance !== e.sq_dist) begin
          $error("sq_distance expected %0d actual %0d", e.sq_dist, sq_distance);
          errors++;
        end
        if (last !== e.last) begin
          $error("last expected %0d actual %0d", e.last, last);
          errors++;
        end
      end
    end
  end

  initial begin
    #100_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    stim_row_t plan[15];
    fill_word_t e;
    int unsigned w, h, total, density, phase;
    logic [7:0] t;
    logic [PAINT_W-1:0] pt;

    plan = '{
      '{FUNC_LOAD, 8'd255, 12'd4095, 1'b0, 12'd0, 32'd0, 1'b0},
      '{FUNC_LOAD, 8'd0, 12'd0, 1'b0, 12'd0, 32'd0, 1'b0},
      '{FUNC_LOAD, 8'd0, 12'd0, 1'b0, 12'd0, 32'd0, 1'b0},
      '{FUNC_LOAD, 8'd0, 12'd0, 1'b0, 12'd0, 32'd0, 1'b0},
      '{FUNC_READ, 8'd0, 12'd0, 1'b1, 12'd4095, 32'd0, 1'b0},
      '{FUNC_READ, 8'd0, 12'd0, 1'b1, 12'd4095, 32'd1, 1'b0},
      '{FUNC_READ, 8'd0, 12'd0, 1'b1, 12'd4095, 32'd1, 1'b0},
      '{FUNC_READ, 8'd0, 12'd0, 1'b1, 12'd4095, 32'd2, 1'b1},
      '{FUNC_READ, 8'd0, 12'd0, 1'b1, 12'd4095, 32'd0, 1'b0},
      '{FUNC_LOAD, 8'd0, 12'd0, 1'b0, 12'd0, 32'd0, 1'b0},
      '{FUNC_LOAD, 8'd0, 12'd0, 1'b0, 12'd0, 32'd0, 1'b0},
      '{FUNC_LOAD, 8'd0, 12'd0, 1'b0, 12'd0, 32'd0, 1'b0},
      '{FUNC_LOAD, 8'd0, 12'd0, 1'b0, 12'd0, 32'd0, 1'b0},
      '{FUNC_READ, 8'd0, 12'd0, 1'b1, 12'd0, NO_SEED, 1'b0},
      '{FUNC_READ, 8'd0, 12'd0, 1'b1, 12'd0, NO_SEED, 1'b0}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(REG_WIDTH, 9'd2);
    write_reg(REG_HEIGHT, 9'd2);
    foreach (plan[k]) begin
      offer(plan[k].func, plan[k].tone, plan[k].paint);
      if (plan[k].typed) begin
        e.paint = plan[k].e_paint;
        e.sq_dist = plan[k].e_dist;
        e.last = plan[k].e_last;
        void'(fill_q.pop_back());
        fill_q.push_back(e);
      end
    end
    drain();

    phase = 0;
    while (items < 900) begin
      case (phase)
        1: begin w = 511; h = 1; end
        3: begin w = 0; h = 0; end
        5: begin w = 1; h = 300; end
        default: begin w = $urandom_range(1, 8); h = $urandom_range(1, 8); end
      endcase
      if (phase >= 4) calm = 1;
      write_reg(REG_WIDTH, w[DIM_W-1:0]);
      write_reg(REG_HEIGHT, h[DIM_W-1:0]);
      total = clamp_dim(w[DIM_W-1:0], MAX_WIDTH) * clamp_dim(h[DIM_W-1:0], MAX_HEIGHT);
      density = $urandom_range(0, 6) == 0 ? 0 : $urandom_range(1, 12);
      for (int unsigned n = 0; n < total; n++) begin
        t = '0;
        pt = '0;
        if (density != 0 && $urandom_range(1, density) == 1) begin
          case ($urandom_range(0, 2))
            0: t = 8'($urandom_range(1, 255));
            1: pt = PAINT_W'($urandom_range(1, 4095));
            default: begin t = 8'($urandom); pt = PAINT_W'($urandom); end
          endcase
        end
        offer(FUNC_LOAD, t, pt);
      end
      if (phase == 2) hold_req = 1;
      if (phase == 5) total = 48;
      else total = total + $urandom_range(0, 3);
      for (int unsigned n = 0; n < total; n++) begin
        offer(FUNC_READ, 8'($urandom), PAINT_W'($urandom));
      end
      drain();
      phase++;
    end

    while (hold_req) @(posedge clk);
    drain();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
